/* design/iapp_pkg.sv */
// Shared types, constants and the angle conversion for the IMU angle packet parser.
// No dependencies; used by every module in the design folder.
package iapp_pkg;

  localparam int PACKET_BYTES = 11;

  // Packet bytes two through nine carry the three angles and the version word.
  localparam int FIELD_FIRST = 2;
  localparam int FIELD_BYTES = 8;

  // Depth of the queue between the framer and the converter.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  FIRST_HEADER_RESET  = 8'd85;
  localparam logic [7:0]  SECOND_HEADER_RESET = 8'd83;

  // Register map: word index taken from paddr[2].
  localparam logic REG_FIRST_HEADER  = 1'b0;
  localparam logic REG_SECOND_HEADER = 1'b1;

  // raw * 180 / 256 in offset binary, then the offset removed again.
  localparam logic [7:0]  ANGLE_SCALE  = 8'd180;
  localparam logic [15:0] ANGLE_OFFSET = 16'd23040;

  // Raw fields of one good packet, as carried through the queue.
  typedef struct packed {
    logic [15:0] version;
    logic [15:0] yaw_bits;
    logic [15:0] pitch_bits;
    logic [15:0] roll_bits;
  } packet_rec_t;

  // Converts a signed little-endian raw angle to Q9.7 degrees, floor rounding.
  function automatic logic [15:0] q97_from_raw(input logic [15:0] raw);
    logic [15:0] biased;
    logic [23:0] product;
    begin
      biased  = {~raw[15], raw[14:0]};
      product = 24'(biased) * 24'(ANGLE_SCALE);
      return product[23:8] - ANGLE_OFFSET;
    end
  endfunction

endpackage

/* design/iapp_framer.sv */
// Front part of the packet parser: header hunt, byte capture and running checksum.
// Depends on iapp_pkg for the packet record type and field positions.
module iapp_framer #(
  parameter int PACKET_BYTES = iapp_pkg::PACKET_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           first_header,
  input  logic [7:0]           second_header,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  logic [7:0]           rx_byte,
  input  logic                 queue_full,
  output logic                 rec_valid,
  output iapp_pkg::packet_rec_t rec
);

  localparam int PW = $clog2(PACKET_BYTES);
  localparam logic [PW-1:0] LAST_POS = PW'(PACKET_BYTES - 1);
  localparam logic [PW-1:0] FIELD_LO = PW'(iapp_pkg::FIELD_FIRST);
  localparam logic [PW-1:0] FIELD_HI = PW'(iapp_pkg::FIELD_FIRST + iapp_pkg::FIELD_BYTES - 1);

  logic [PW-1:0] position;
  logic [7:0]    running_sum;
  logic [7:0]    stored_first;
  logic [7:0]    stored_second;
  logic [7:0]    field_store [iapp_pkg::FIELD_BYTES];

  logic          accept;
  logic          at_last;
  logic          good;
  logic [7:0]    field_byte [iapp_pkg::FIELD_BYTES];
  logic [PW-1:0] field_index;

  assign at_last     = (position == LAST_POS);
  // Only the checksum byte needs queue space; other bytes always flow.
  assign byte_ready  = !(at_last && queue_full);
  assign accept      = byte_valid && byte_ready;
  assign field_index = position - FIELD_LO;

  assign good = (rx_byte == running_sum) && (stored_first == first_header) &&
                (stored_second == second_header);
  assign rec_valid = accept && at_last && good;

  // The checksum byte can also be a field byte in the shortest packet.
  always_comb begin
    for (int k = 0; k < iapp_pkg::FIELD_BYTES; k++) begin
      field_byte[k] = (position == PW'(k + iapp_pkg::FIELD_FIRST)) ? rx_byte : field_store[k];
    end
    rec.roll_bits  = {field_byte[1], field_byte[0]};
    rec.pitch_bits = {field_byte[3], field_byte[2]};
    rec.yaw_bits   = {field_byte[5], field_byte[4]};
    rec.version    = {field_byte[7], field_byte[6]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      running_sum <= '0;
    end else if (accept) begin
      if (position == '0 || (position == PW'(1) && rx_byte != second_header)) begin
        if (rx_byte == first_header) begin
          position    <= PW'(1);
          running_sum <= rx_byte;
        end else begin
          position    <= '0;
          running_sum <= '0;
        end
      end else if (at_last) begin
        position    <= '0;
        running_sum <= '0;
      end else begin
        position    <= position + PW'(1);
        running_sum <= running_sum + rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (position == '0 || position == PW'(1)) begin
        if (position == PW'(1) && rx_byte == second_header) begin
          stored_second <= rx_byte;
        end else if (rx_byte == first_header) begin
          stored_first <= rx_byte;
        end
      end
      if (position >= FIELD_LO && position <= FIELD_HI) begin
        field_store[field_index[$clog2(iapp_pkg::FIELD_BYTES)-1:0]] <= rx_byte;
      end
    end
  end

endmodule

/* design/iapp_queue.sv */
// Short queue of packet records between the framer and the converter.
// Depends on iapp_pkg for the record type and the queue depth.
module iapp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  iapp_pkg::packet_rec_t push_rec,
  output logic                  full,
  output logic                  not_empty,
  input  logic                  pop,
  output iapp_pkg::packet_rec_t head_rec
);

  localparam int DEPTH = iapp_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  iapp_pkg::packet_rec_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_rec  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

/* design/iapp_convert.sv */
// Back part of the packet parser: angle conversion, packet count and output register.
// Depends on iapp_pkg for the record type and the Q9.7 conversion function.
module iapp_convert (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rec_valid,
  input  iapp_pkg::packet_rec_t rec,
  output logic                  rec_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [95:0]           out_data
);

  logic [31:0] packet_counter;
  logic [31:0] packet_counter_next;

  assign rec_pop             = rec_valid && (!out_valid || out_ready);
  assign packet_counter_next = packet_counter + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      packet_counter <= '0;
    end else begin
      if (rec_pop) begin
        out_valid      <= 1'b1;
        packet_counter <= packet_counter_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      out_data <= {packet_counter_next,
                   rec.version,
                   iapp_pkg::q97_from_raw(rec.yaw_bits),
                   iapp_pkg::q97_from_raw(rec.pitch_bits),
                   iapp_pkg::q97_from_raw(rec.roll_bits)};
    end
  end

endmodule

/* design/imu_angle_packet_parser.sv */
// Top level of the IMU angle packet parser: configuration registers and stream ports.
// Depends on iapp_pkg, iapp_framer, iapp_queue and iapp_convert.
//
// Usage: received serial bytes enter one per transaction on the s_ group. The block
// hunts for the two header bytes held in the configuration registers, collects
// PACKET_BYTES bytes and checks that the last byte is the modulo-256 sum of all the
// bytes before it. A good packet leaves as one transaction on the m_ group with
// roll, pitch and yaw in Q9.7 degrees, the version word and the good packet count.
// Bad packets produce nothing, and parsing restarts after every complete packet.
// Throughput is one byte per cycle but for the checksum hold described below. A
// good record goes into the queue and then into the converter's output register,
// with the three 16x8 scale multiplies in front of that register, which drives
// m_tvalid. When the receiver stalls, results wait in the output register and then
// in the two-entry queue; bytes keep flowing, and only a checksum byte is held off
// while the queue is full. Reset clears the packet position, checksum, packet count
// and all valid flags, and restores the header registers to 0x55 and 0x53. Header
// registers are to be written through the APB port only while no packet is in
// progress; the user must keep to this, as the block does not enforce it.
module imu_angle_packet_parser #(
  parameter int PACKET_BYTES = iapp_pkg::PACKET_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata    // [15:0] roll_angle, [31:16] pitch_angle,
                                 // [47:32] yaw_angle, [63:48] sensor_version,
                                 // [95:64] good_packets
);

  logic [7:0] first_header_byte;
  logic [7:0] second_header_byte;

  logic                  cfg_write;
  logic                  rec_push;
  iapp_pkg::packet_rec_t push_rec;
  iapp_pkg::packet_rec_t head_rec;
  logic                  queue_full;
  logic                  queue_not_empty;
  logic                  rec_pop;

  // The port never waits; a write lands in the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_header_byte  <= iapp_pkg::FIRST_HEADER_RESET;
      second_header_byte <= iapp_pkg::SECOND_HEADER_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        iapp_pkg::REG_FIRST_HEADER:  first_header_byte  <= pwdata[7:0];
        iapp_pkg::REG_SECOND_HEADER: second_header_byte <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      iapp_pkg::REG_FIRST_HEADER:  prdata = {24'd0, first_header_byte};
      iapp_pkg::REG_SECOND_HEADER: prdata = {24'd0, second_header_byte};
      default:                     prdata = '0;
    endcase
  end

  // The framer follows the byte stream and emits one record per good packet.
  iapp_framer #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_framer (
    .clk          (clk),
    .rst          (rst),
    .first_header (first_header_byte),
    .second_header(second_header_byte),
    .byte_valid   (s_tvalid),
    .byte_ready   (s_tready),
    .rx_byte      (s_tdata),
    .queue_full   (queue_full),
    .rec_valid    (rec_push),
    .rec          (push_rec)
  );

  // The queue lets the framer keep taking bytes while the result side is stalled.
  iapp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_push),
    .push_rec (push_rec),
    .full     (queue_full),
    .not_empty(queue_not_empty),
    .pop      (rec_pop),
    .head_rec (head_rec)
  );

  // The converter scales the angles, counts good packets and holds the result.
  iapp_convert u_convert (
    .clk      (clk),
    .rst      (rst),
    .rec_valid(queue_not_empty),
    .rec      (head_rec),
    .rec_pop  (rec_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata)
  );

endmodule

/* bench/iapp_angle_checker.sv */
// Checker for the IMU angle packet parser: watches the APB port and both streams,
// predicts every result from the received bytes and compares field by field.
// Depends on iapp_pkg for the packet length, header reset values and register codes.
module iapp_angle_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Same layout as m_tdata: roll in the lowest bits, packet count in the highest.
  typedef struct packed {
    logic [31:0] good_packets;
    logic [15:0] version;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
  } angle_report_t;

  logic [7:0]    first_hdr;
  logic [7:0]    second_hdr;
  int unsigned   frame_pos;
  logic [7:0]    frame_bytes [iapp_pkg::PACKET_BYTES];
  logic [7:0]    frame_sum;
  logic [31:0]   good_count;
  angle_report_t expected_reports [$];
  int            error_tally = 0;

  // Signed little-endian raw angle times 180, divided by 256 with floor rounding.
  function automatic logic [15:0] degrees_q97(input logic [7:0] lo, input logic [7:0] hi);
    int scaled;
    scaled = $signed({hi, lo}) * 180;
    return 16'(scaled >>> 8);
  endfunction

  function automatic void compare_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      error_tally++;
    end
  endfunction

  always @(posedge clk) begin : track
    angle_report_t seen;
    angle_report_t want;
    logic [7:0]    rx;
    if (rst) begin
      first_hdr  = iapp_pkg::FIRST_HEADER_RESET;
      second_hdr = iapp_pkg::SECOND_HEADER_RESET;
      frame_pos  = 0;
      frame_sum  = '0;
      good_count = '0;
      expected_reports.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        rx = s_tdata;
        if (frame_pos == 0 || (frame_pos == 1 && rx != second_hdr)) begin
          // Hunting; a failed second header may itself open a new packet.
          frame_pos = 0;
          frame_sum = '0;
          if (rx == first_hdr) begin
            frame_bytes[0] = rx;
            frame_sum      = rx;
            frame_pos      = 1;
          end
        end else if (frame_pos < iapp_pkg::PACKET_BYTES - 1) begin
          frame_bytes[frame_pos] = rx;
          frame_sum += rx;
          frame_pos++;
        end else begin
          // Checksum byte. The stored headers are checked again against the
          // registers as they stand now.
          frame_bytes[iapp_pkg::PACKET_BYTES - 1] = rx;
          if (rx == frame_sum && frame_bytes[0] == first_hdr &&
              frame_bytes[1] == second_hdr) begin
            good_count++;
            want.roll         = degrees_q97(frame_bytes[2], frame_bytes[3]);
            want.pitch        = degrees_q97(frame_bytes[4], frame_bytes[5]);
            want.yaw          = degrees_q97(frame_bytes[6], frame_bytes[7]);
            want.version      = {frame_bytes[9], frame_bytes[8]};
            want.good_packets = good_count;
            expected_reports.push_back(want);
          end
          frame_pos = 0;
          frame_sum = '0;
        end
      end

      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == iapp_pkg::REG_FIRST_HEADER) begin
          first_hdr = pwdata[7:0];
        end else begin
          second_hdr = pwdata[7:0];
        end
      end

      if (m_tvalid && m_tready) begin
        seen = m_tdata;
        if (expected_reports.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h", $time, m_tdata);
          error_tally++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("roll_angle", 32'(want.roll), 32'(seen.roll));
          compare_field("pitch_angle", 32'(want.pitch), 32'(seen.pitch));
          compare_field("yaw_angle", 32'(want.yaw), 32'(seen.yaw));
          compare_field("sensor_version", 32'(want.version), 32'(seen.version));
          compare_field("good_packets", want.good_packets, seen.good_packets);
        end
      end
    end
    outstanding <= expected_reports.size();
    mismatches  <= error_tally;
  end

endmodule

/* bench/tb_top.sv */
// Testbench top for the IMU angle packet parser: clock, reset, byte stimulus,
// header register writes, receiver back-pressure and the final verdict.
// Depends on iapp_pkg, the imu_angle_packet_parser RTL and iapp_angle_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES         = 12;
  localparam int PHASE_BYTES    = 140;
  // A result leaves via the record queue and output register; a dropped packet leaves
  // nothing, so the DRAIN_CYCLES wait covers it before a register write or the end.
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [iapp_pkg::PACKET_BYTES-1:0][7:0] packet_bytes_t;

  // Receiver behavior, chosen afresh at random by receiver_stalls.
  typedef enum {READY_ALWAYS, READY_COIN, READY_LONG_STALLS} stall_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;         // [15:0] roll_angle, [31:16] pitch_angle,
                                // [47:32] yaw_angle, [63:48] sensor_version,
                                // [95:64] good_packets
  int          mismatches;
  int          outstanding;

  // Header values the stimulus frames its packets with; they follow every write.
  logic [7:0]  first_hdr  = iapp_pkg::FIRST_HEADER_RESET;
  logic [7:0]  second_hdr = iapp_pkg::SECOND_HEADER_RESET;

  // Sender burst state: bytes left in the current burst and whether gaps are allowed.
  int          burst_left = 0;
  bit          gaps_on    = 1'b1;

  stall_mode_t stall_mode = READY_ALWAYS;
  int          mode_left  = 0;
  int          hold_left  = 0;

  imu_angle_packet_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  iapp_angle_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure. Modes alternate between always ready, a coin toss per
  // cycle, and mostly ready with occasional long stalls that fill the record queue
  // and so hold off checksum bytes on the input side.
  always @(posedge clk) begin : receiver_stalls
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(40, 300);
    end
    mode_left--;
    case (stall_mode)
      READY_ALWAYS: begin
        m_tready <= 1'b1;
      end
      READY_COIN: begin
        m_tready <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          hold_left = $urandom_range(5, 30);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // Ends the run if neither stream moves a transaction for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("imu_angle_packet_parser regression: fail");
    $finish;
  end

  // Sends one byte. Bursts of random length are separated by random gaps, so the
  // pauses land on every byte position of a packet. tvalid stays high within a burst.
  task automatic push_byte(input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tdata  <= value;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops sending, waits for every expected result, then lets a dropped packet settle.
  // The first edge lets the checker count a checksum byte taken at the last edge.
  task automatic quiesce();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  task automatic apb_write(input logic reg_sel, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_headers(input logic [7:0] h0, input logic [7:0] h1);
    quiesce();
    apb_write(iapp_pkg::REG_FIRST_HEADER, h0);
    apb_write(iapp_pkg::REG_SECOND_HEADER, h1);
    first_hdr  = h0;
    second_hdr = h1;
  endtask

  // Builds a packet with the current headers; a nonzero sum_error spoils the checksum.
  function automatic packet_bytes_t frame_packet(input logic [15:0] roll,
                                                 input logic [15:0] pitch,
                                                 input logic [15:0] yaw,
                                                 input logic [15:0] version,
                                                 input logic [7:0]  sum_error);
    packet_bytes_t pkt;
    logic [7:0]    sum;
    for (int i = 0; i < iapp_pkg::PACKET_BYTES; i++) begin
      pkt[i] = 8'($urandom);
    end
    pkt[0] = first_hdr;
    pkt[1] = second_hdr;
    {pkt[3], pkt[2]} = roll;
    {pkt[5], pkt[4]} = pitch;
    {pkt[7], pkt[6]} = yaw;
    {pkt[9], pkt[8]} = version;
    sum = '0;
    for (int i = 0; i < iapp_pkg::PACKET_BYTES - 1; i++) begin
      sum += pkt[i];
    end
    pkt[iapp_pkg::PACKET_BYTES - 1] = sum + sum_error;
    return pkt;
  endfunction

  task automatic send_packet(input logic [15:0] roll, input logic [15:0] pitch,
                             input logic [15:0] yaw, input logic [15:0] version,
                             input logic [7:0] sum_error);
    packet_bytes_t pkt;
    pkt = frame_packet(roll, pitch, yaw, version, sum_error);
    for (int i = 0; i < iapp_pkg::PACKET_BYTES; i++) begin
      push_byte(pkt[i]);
    end
  endtask

  // Mostly random raw values, with the signed extremes and zero mixed in.
  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // A byte that can never open a packet while the parser is hunting.
  function automatic logic [7:0] noise_byte();
    logic [7:0] v;
    v = 8'($urandom);
    return (v == first_hdr) ? ~v : v;
  endfunction

  initial begin : stimulus
    packet_bytes_t pkt;
    logic [7:0]    h0;
    logic [7:0]    h1;
    logic [7:0]    fail_byte;
    int            sent;
    int            pick;
    int            cut;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the reset header values. A second header that fails on
    // a copy of the first header restarts the packet at that byte; the packet
    // after it carries the angle extremes and the largest version word.
    push_byte(first_hdr);
    send_packet(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 8'h00);
    // Bad checksum: dropped without a result, hunting resumes.
    send_packet(16'h0000, 16'h0001, 16'h7FFF, 16'h0000, 8'h01);
    // Header register rewritten while a packet is half collected: the packet is
    // dropped at its checksum because its stored first header no longer matches.
    pkt = frame_packet(16'h1234, 16'hC000, 16'h4000, 16'h00FF, 8'h00);
    for (int i = 0; i < 5; i++) begin
      push_byte(pkt[i]);
    end
    quiesce();
    apb_write(iapp_pkg::REG_FIRST_HEADER, 8'hAA);
    first_hdr = 8'hAA;
    for (int i = 5; i < iapp_pkg::PACKET_BYTES; i++) begin
      push_byte(pkt[i]);
    end

    // Random part: one header setting per phase, reset values and extremes first. Most
    // traffic is well-formed packets; the rest is spoiled checksums, failed second
    // headers, packets cut short and stray bytes.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin h0 = iapp_pkg::FIRST_HEADER_RESET; h1 = iapp_pkg::SECOND_HEADER_RESET; end
        1: begin h0 = 8'h00; h1 = 8'h00; end
        2: begin h0 = 8'hFF; h1 = 8'hFF; end
        3: begin h0 = 8'h00; h1 = 8'hFF; end
        4: begin h0 = 8'hFF; h1 = 8'h00; end
        default: begin
          h0 = 8'($urandom);
          h1 = ($urandom_range(0, 3) == 0) ? h0 : 8'($urandom);
        end
      endcase
      set_headers(h0, h1);
      gaps_on = (phase % 4 != 1);
      sent    = 0;
      while (sent < PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          send_packet(pick_raw(), pick_raw(), pick_raw(), pick_raw(), 8'h00);
          sent += iapp_pkg::PACKET_BYTES;
        end else if (pick < 70) begin
          send_packet(pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                      8'($urandom_range(1, 255)));
          sent += iapp_pkg::PACKET_BYTES;
        end else if (pick < 80) begin
          push_byte(first_hdr);
          if (first_hdr != second_hdr && $urandom_range(0, 1) == 1) begin
            // The failing byte is a first header and opens the next packet.
            send_packet(pick_raw(), pick_raw(), pick_raw(), pick_raw(), 8'h00);
            sent += iapp_pkg::PACKET_BYTES + 1;
          end else begin
            fail_byte = noise_byte();
            if (fail_byte == second_hdr) begin
              fail_byte = fail_byte ^ 8'h01;
              if (fail_byte == first_hdr) begin
                fail_byte = fail_byte ^ 8'h03;
              end
            end
            push_byte(fail_byte);
            sent += 2;
          end
        end else if (pick < 88) begin
          // Packet cut short; stray bytes complete it and leave the parser hunting.
          pkt = frame_packet(pick_raw(), pick_raw(), pick_raw(), pick_raw(), 8'h00);
          cut = $urandom_range(2, iapp_pkg::PACKET_BYTES - 1);
          for (int i = 0; i < cut; i++) begin
            push_byte(pkt[i]);
          end
          for (int i = 0; i < iapp_pkg::PACKET_BYTES; i++) begin
            push_byte(noise_byte());
          end
          sent += cut + iapp_pkg::PACKET_BYTES;
        end else begin
          cut = $urandom_range(1, 12);
          for (int i = 0; i < cut; i++) begin
            push_byte(noise_byte());
          end
          sent += cut;
        end
      end
    end

    quiesce();
    if (mismatches == 0 && outstanding == 0) begin
      $display("imu_angle_packet_parser regression: pass");
    end else begin
      $display("imu_angle_packet_parser regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/iapp_pkg.sv
design/iapp_framer.sv
design/iapp_queue.sv
design/iapp_convert.sv
design/imu_angle_packet_parser.sv
bench/iapp_angle_checker.sv
bench/tb_top.sv
